>>> sv/cbz_pkg.sv
// ----------------------------------------------------------------------------
// cbz_pkg
// shared constants, register indexes and pipeline control type for the
// cubic bezier point generator
// ----------------------------------------------------------------------------
package cbz_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int INDEX_BITS      = 16;
  localparam int COLOR_BITS      = 24;

  localparam int                    T_STEP_RESET = 66;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET  = 24'h0000FF;

  typedef enum logic [0:0] {
    CFG_T_STEP      = 1'b0,
    CFG_PIXEL_COLOR = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic valid;
    logic curve_end;
  } cbz_ctrl_t;

endpackage

>>> sv/cbz_in_if.sv
// ----------------------------------------------------------------------------
// cbz_in_if
// input channel: four control points and a sample index per word
// ----------------------------------------------------------------------------
interface cbz_in_if #(
  parameter int COORD_BITS = cbz_pkg::COORD_BITS_DEF
);
  import cbz_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] ctrl_x0;
  logic [COORD_BITS-1:0] ctrl_y0;
  logic [COORD_BITS-1:0] ctrl_x1;
  logic [COORD_BITS-1:0] ctrl_y1;
  logic [COORD_BITS-1:0] ctrl_x2;
  logic [COORD_BITS-1:0] ctrl_y2;
  logic [COORD_BITS-1:0] ctrl_x3;
  logic [COORD_BITS-1:0] ctrl_y3;
  logic [INDEX_BITS-1:0] sample_index;

  modport source (
    output valid, ctrl_x0, ctrl_y0, ctrl_x1, ctrl_y1,
    output ctrl_x2, ctrl_y2, ctrl_x3, ctrl_y3, sample_index,
    input  ready
  );

  modport sink (
    input  valid, ctrl_x0, ctrl_y0, ctrl_x1, ctrl_y1,
    input  ctrl_x2, ctrl_y2, ctrl_x3, ctrl_y3, sample_index,
    output ready
  );

endinterface

>>> sv/cbz_out_if.sv
// ----------------------------------------------------------------------------
// cbz_out_if
// result channel: one pixel with color and end flag per word
// ----------------------------------------------------------------------------
interface cbz_out_if #(
  parameter int COORD_BITS = cbz_pkg::COORD_BITS_DEF
);
  import cbz_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0] color_out;
  logic                  curve_end;

  modport source (
    output valid, pixel_x, pixel_y, color_out, curve_end,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, color_out, curve_end,
    output ready
  );

endinterface

>>> sv/cbz_cfg_if.sv
// ----------------------------------------------------------------------------
// cbz_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface cbz_cfg_if #(
  parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
);
  import cbz_pkg::*;

  localparam int DATA_BITS = (T_FRAC_BITS + 1 > COLOR_BITS) ? T_FRAC_BITS + 1 : COLOR_BITS;

  logic                 valid;
  logic                 ready;
  cfg_index_t           index;
  logic [DATA_BITS-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

>>> sv/cubic_bezier_point_generator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator
// evaluates a cubic bezier point at t = min(k * t_step, 1) by fixed-point
// de casteljau subdivision and rounds it half up to pixel coordinates
//
//   channel    dir   handshake        word
//   in_port    in    valid / ready    ctrl_x0..ctrl_y3, sample_index
//   out_port   out   valid / ready    pixel_x, pixel_y, color_out, curve_end
//   cfg_port   in    valid / ready    index, data (t_step, pixel_color)
//
// one word per clock sustained while out_port takes words; registers in order: product k * t_step,
// clamp of t, three subdivision levels of three stages each, rounding
// into the output register.
// reset (synchronous, active low) clears all valid bits and loads
// t_step = 66 and pixel_color = 0xff; the config port is always ready.
// each stage advances when it is empty or the next one moves, so empty
// slots close up under a stall and in_port stays ready until all are full.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator #(
  parameter  int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
  parameter  int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF,
  localparam int VW          = COORD_BITS + T_FRAC_BITS + 1,
  localparam int TW          = T_FRAC_BITS + 1
) (
  input  logic      clk,
  input  logic      rst_n,
  cbz_in_if.sink    in_port,
  cbz_out_if.source out_port,
  cbz_cfg_if.sink   cfg_port
);
  import cbz_pkg::*;

  localparam int PRW = INDEX_BITS + TW;
  localparam int CFW = COORD_BITS + T_FRAC_BITS;

  localparam logic [TW-1:0]  T_ONE    = TW'(1) << T_FRAC_BITS;
  localparam logic [CFW-1:0] HALF_LSB = CFW'(1) << (T_FRAC_BITS - 1);

  // config registers
  logic [TW-1:0]         t_step_r;
  logic [COLOR_BITS-1:0] pixel_color_r;

  // stage a: parameter product and shifted control points
  logic                 va_r;
  logic [PRW-1:0]       prod_a_r;
  logic [PRW-1:0]       prod_nxt;
  logic signed [VW-1:0] pts_a_r [2][4];
  logic signed [VW-1:0] pts_nxt [2][4];

  // stage b: clamped t
  cbz_ctrl_t            ctrl_b_r;
  cbz_ctrl_t            ctrl_b_nxt;
  logic [TW-1:0]        t_b_r;
  logic [TW-1:0]        t_nxt;
  logic signed [VW-1:0] pts_b_r [2][4];

  // subdivision levels
  cbz_ctrl_t            l1_ctrl, l2_ctrl, l3_ctrl;
  logic [TW-1:0]        l1_t, l2_t, l3_t;
  logic signed [VW-1:0] l1_pts [2][3];
  logic signed [VW-1:0] l2_pts [2][2];
  logic signed [VW-1:0] l3_pts [2][1];
  logic                 l1_ready, l2_ready, l3_ready;

  // output register
  cbz_ctrl_t             out_ctrl_r;
  logic [COORD_BITS-1:0] pixel_x_r, pixel_y_r;
  logic [CFW-1:0]        rnd_nxt [2];

  logic en_a, en_b, en_o;

  assign en_o = !out_ctrl_r.valid || out_port.ready;
  assign en_b = !ctrl_b_r.valid || l1_ready;
  assign en_a = !va_r || en_b;

  assign in_port.ready  = en_a;
  assign cfg_port.ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_step_r      <= TW'(T_STEP_RESET);
      pixel_color_r <= COLOR_RESET;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        CFG_T_STEP:      t_step_r      <= cfg_port.data[TW-1:0];
        CFG_PIXEL_COLOR: pixel_color_r <= cfg_port.data[COLOR_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // stage a logic
  always_comb begin
    prod_nxt = PRW'(in_port.sample_index) * PRW'(t_step_r);
    pts_nxt[0][0] = $signed({1'b0, in_port.ctrl_x0, {T_FRAC_BITS{1'b0}}});
    pts_nxt[0][1] = $signed({1'b0, in_port.ctrl_x1, {T_FRAC_BITS{1'b0}}});
    pts_nxt[0][2] = $signed({1'b0, in_port.ctrl_x2, {T_FRAC_BITS{1'b0}}});
    pts_nxt[0][3] = $signed({1'b0, in_port.ctrl_x3, {T_FRAC_BITS{1'b0}}});
    pts_nxt[1][0] = $signed({1'b0, in_port.ctrl_y0, {T_FRAC_BITS{1'b0}}});
    pts_nxt[1][1] = $signed({1'b0, in_port.ctrl_y1, {T_FRAC_BITS{1'b0}}});
    pts_nxt[1][2] = $signed({1'b0, in_port.ctrl_y2, {T_FRAC_BITS{1'b0}}});
    pts_nxt[1][3] = $signed({1'b0, in_port.ctrl_y3, {T_FRAC_BITS{1'b0}}});
  end

  // stage b logic: clamp t to one
  always_comb begin
    ctrl_b_nxt.valid     = va_r;
    ctrl_b_nxt.curve_end = (prod_a_r >= PRW'(T_ONE));
    t_nxt = ctrl_b_nxt.curve_end ? T_ONE : {1'b0, prod_a_r[T_FRAC_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      ctrl_b_r <= '0;
    end else begin
      if (en_a) va_r     <= in_port.valid;
      if (en_b) ctrl_b_r <= ctrl_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_a_r <= prod_nxt;
      pts_a_r  <= pts_nxt;
    end
    if (en_b) begin
      t_b_r   <= t_nxt;
      pts_b_r <= pts_a_r;
    end
  end

  cbz_lerp_level #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS),
    .NUM_OUT    (3)
  ) u_level1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_ctrl (ctrl_b_r),
    .up_t    (t_b_r),
    .up_pts  (pts_b_r),
    .up_ready(l1_ready),
    .dn_ctrl (l1_ctrl),
    .dn_t    (l1_t),
    .dn_pts  (l1_pts),
    .dn_ready(l2_ready)
  );

  cbz_lerp_level #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS),
    .NUM_OUT    (2)
  ) u_level2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_ctrl (l1_ctrl),
    .up_t    (l1_t),
    .up_pts  (l1_pts),
    .up_ready(l2_ready),
    .dn_ctrl (l2_ctrl),
    .dn_t    (l2_t),
    .dn_pts  (l2_pts),
    .dn_ready(l3_ready)
  );

  cbz_lerp_level #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS),
    .NUM_OUT    (1)
  ) u_level3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_ctrl (l2_ctrl),
    .up_t    (l2_t),
    .up_pts  (l2_pts),
    .up_ready(l3_ready),
    .dn_ctrl (l3_ctrl),
    .dn_t    (l3_t),
    .dn_pts  (l3_pts),
    .dn_ready(en_o)
  );

  // round half up; curve point is never negative
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd_nxt[l] = l3_pts[l][0][CFW-1:0] + HALF_LSB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctrl_r <= '0;
    end else if (en_o) begin
      out_ctrl_r <= l3_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      pixel_x_r <= rnd_nxt[0][CFW-1:T_FRAC_BITS];
      pixel_y_r <= rnd_nxt[1][CFW-1:T_FRAC_BITS];
    end
  end

  assign out_port.valid     = out_ctrl_r.valid;
  assign out_port.pixel_x   = pixel_x_r;
  assign out_port.pixel_y   = pixel_y_r;
  assign out_port.color_out = pixel_color_r;
  assign out_port.curve_end = out_ctrl_r.curve_end;

`ifndef SYNTHESIS
  a_end_means_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_b_r.valid && ctrl_b_r.curve_end |-> t_b_r == T_ONE)
    else $error("end flag set but t is not one");

  a_no_end_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_b_r.valid && !ctrl_b_r.curve_end |-> t_b_r < T_ONE)
    else $error("t reached one without end flag");

  a_take_fills_a: assert property (@(posedge clk) disable iff (!rst_n)
    in_port.valid && in_port.ready |=> va_r)
    else $error("accepted word lost at product stage");

  a_product_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && !en_b |=> va_r && $stable(prod_a_r))
    else $error("product stage changed while stalled");

  a_l3_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    l3_ctrl.valid |-> l3_t <= T_ONE)
    else $error("t above one at last level");
`endif

endmodule

>>> sv/cbz_lerp_level.sv
// ----------------------------------------------------------------------------
// cbz_lerp_level
// one de casteljau level for x and y: difference, multiply by t, floor
// shift and add, three register stages with per-stage stall
// ----------------------------------------------------------------------------
module cbz_lerp_level #(
  parameter  int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
  parameter  int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF,
  parameter  int NUM_OUT     = 3,
  localparam int VW          = COORD_BITS + T_FRAC_BITS + 1,
  localparam int TW          = T_FRAC_BITS + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cbz_pkg::cbz_ctrl_t  up_ctrl,
  input  logic [TW-1:0]       up_t,
  input  logic signed [VW-1:0] up_pts [2][NUM_OUT+1],
  output logic                up_ready,
  output cbz_pkg::cbz_ctrl_t  dn_ctrl,
  output logic [TW-1:0]       dn_t,
  output logic signed [VW-1:0] dn_pts [2][NUM_OUT],
  input  logic                dn_ready
);
  import cbz_pkg::*;

  localparam int PW = VW + TW + 1;

  cbz_ctrl_t           ctrl0_r, ctrl1_r, ctrl2_r;
  logic [TW-1:0]       t0_r, t1_r, t2_r;
  logic signed [VW-1:0] base0_r [2][NUM_OUT];
  logic signed [VW-1:0] diff0_r [2][NUM_OUT];
  logic signed [VW-1:0] base1_r [2][NUM_OUT];
  logic signed [PW-1:0] prod1_r [2][NUM_OUT];
  logic signed [VW-1:0] pt2_r   [2][NUM_OUT];

  logic signed [VW-1:0] diff_nxt [2][NUM_OUT];
  logic signed [PW-1:0] prod_nxt [2][NUM_OUT];
  logic signed [PW-1:0] shr      [2][NUM_OUT];
  logic signed [VW-1:0] pt_nxt   [2][NUM_OUT];

  logic en0, en1, en2;

  assign en2      = !ctrl2_r.valid || dn_ready;
  assign en1      = !ctrl1_r.valid || en2;
  assign en0      = !ctrl0_r.valid || en1;
  assign up_ready = en0;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < NUM_OUT; i++) begin
        diff_nxt[l][i] = up_pts[l][i+1] - up_pts[l][i];
        prod_nxt[l][i] = $signed(PW'(diff0_r[l][i])) * $signed({1'b0, t0_r});
        // arithmetic shift gives floor toward minus infinity
        shr[l][i]      = prod1_r[l][i] >>> T_FRAC_BITS;
        pt_nxt[l][i]   = base1_r[l][i] + $signed(shr[l][i][VW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r <= '0;
      ctrl1_r <= '0;
      ctrl2_r <= '0;
    end else begin
      if (en0) ctrl0_r <= up_ctrl;
      if (en1) ctrl1_r <= ctrl0_r;
      if (en2) ctrl2_r <= ctrl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      t0_r <= up_t;
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < NUM_OUT; i++) begin
          base0_r[l][i] <= up_pts[l][i];
          diff0_r[l][i] <= diff_nxt[l][i];
        end
      end
    end
    if (en1) begin
      t1_r <= t0_r;
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < NUM_OUT; i++) begin
          base1_r[l][i] <= base0_r[l][i];
          prod1_r[l][i] <= prod_nxt[l][i];
        end
      end
    end
    if (en2) begin
      t2_r <= t1_r;
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < NUM_OUT; i++) begin
          pt2_r[l][i] <= pt_nxt[l][i];
        end
      end
    end
  end

  assign dn_ctrl = ctrl2_r;
  assign dn_t    = t2_r;
  assign dn_pts  = pt2_r;

`ifndef SYNTHESIS
  a_take_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    up_ctrl.valid && en0 |=> ctrl0_r.valid)
    else $error("accepted word did not reach difference stage");

  a_mult_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl1_r.valid && !en1 |=> ctrl1_r.valid && $stable(t1_r))
    else $error("multiply stage changed while stalled");

  a_last_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl2_r.valid && !dn_ready |=> ctrl2_r.valid && $stable(ctrl2_r.curve_end))
    else $error("level output dropped while stalled");
`endif

endmodule

>>> test/cbz_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbz_point_checker
// watches the input, result and register channels of the cubic bezier point
// generator, keeps its own copy of t_step and pixel_color, predicts the pixel
// for every accepted word by fixed-point de casteljau subdivision and checks
// each result word in order against the oldest predicted pixel
// ----------------------------------------------------------------------------
module cbz_point_checker (
  input  logic clk,
  input  logic rst_n,
  cbz_in_if    in_ch,
  cbz_out_if   out_ch,
  cbz_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   end_count
);
  import cbz_pkg::*;

  localparam int TF   = T_FRAC_BITS_DEF;
  localparam int CB   = COORD_BITS_DEF;
  localparam int STEP = TF + 1;

  typedef struct {
    logic [CB-1:0]         px;
    logic [CB-1:0]         py;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_word_t;

  pixel_word_t           expected_pixels [$];
  logic [STEP-1:0]       step_q;
  logic [COLOR_BITS-1:0] color_q;
  pixel_word_t           got;
  pixel_word_t           want;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    end_count  = 0;
    step_q     = STEP'(T_STEP_RESET);
    color_q    = COLOR_RESET;
  end

  function automatic logic [CB-1:0] bezier_axis(input logic [CB-1:0] c0, input logic [CB-1:0] c1,
                                                input logic [CB-1:0] c2, input logic [CB-1:0] c3,
                                                input logic [STEP-1:0] t);
    longint pt [4];
    longint rounded;
    pt[0] = longint'(c0) << TF;
    pt[1] = longint'(c1) << TF;
    pt[2] = longint'(c2) << TF;
    pt[3] = longint'(c3) << TF;
    for (int lvl = 3; lvl > 0; lvl--)
      for (int i = 0; i < lvl; i++)
        pt[i] = pt[i] + (((pt[i+1] - pt[i]) * longint'(t)) >>> TF);
    rounded = (pt[0] + (longint'(1) << (TF - 1))) >>> TF;
    return rounded[CB-1:0];
  endfunction

  function automatic pixel_word_t predict_pixel();
    pixel_word_t     p;
    longint          t_full;
    logic [STEP-1:0] t;
    t_full  = longint'(in_ch.sample_index) * longint'(step_q);
    p.last  = (t_full >= (longint'(1) << TF));
    t       = p.last ? STEP'(longint'(1) << TF) : t_full[STEP-1:0];
    p.px    = bezier_axis(in_ch.ctrl_x0, in_ch.ctrl_x1, in_ch.ctrl_x2, in_ch.ctrl_x3, t);
    p.py    = bezier_axis(in_ch.ctrl_y0, in_ch.ctrl_y1, in_ch.ctrl_y2, in_ch.ctrl_y3, t);
    p.color = color_q;
    return p;
  endfunction

  task automatic report_field(input string name, input longint exp_v, input longint got_v);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_q  = STEP'(T_STEP_RESET);
      color_q = COLOR_RESET;
      expected_pixels.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_pixels.insert(expected_pixels.size(), predict_pixel());
      if (out_ch.valid && out_ch.ready) begin
        got.px    = out_ch.pixel_x;
        got.py    = out_ch.pixel_y;
        got.color = out_ch.color_out;
        got.last  = out_ch.curve_end;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected word, expected none, got x=0x%0h y=0x%0h", $time,
                   got.px, got.py);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (want.last)
            end_count++;
          if (got.px !== want.px)
            report_field("pixel_x", want.px, got.px);
          if (got.py !== want.py)
            report_field("pixel_y", want.py, got.py);
          if (got.color !== want.color)
            report_field("color_out", want.color, got.color);
          if (got.last !== want.last)
            report_field("curve_end", want.last, got.last);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_T_STEP)
          step_q = cfg_ch.data[STEP-1:0];
        else if (cfg_ch.index == CFG_PIXEL_COLOR)
          color_q = cfg_ch.data[COLOR_BITS-1:0];
      end
    end
    pending = expected_pixels.size();
  end

endmodule

>>> test/cubic_bezier_point_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_tb
// drives curves through the cubic bezier point generator: directed words at
// the field extremes, the parameter clamp, a zero step and half-way rounding,
// then random curves under several t_step and color settings, with random
// idle bursts on both channels and a quiet final phase; the checker predicts
// and compares every pixel
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator_tb;
  import cbz_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASE_WORDS    = 100;

  logic clk;
  logic rst_n;
  bit   calm_tail;
  int   fail_count;
  int   pending;
  int   checked;
  int   end_count;
  int   reg_writes;
  int   idle_cycles;
  int   cur_step;
  bit   in_gaps;

  cbz_in_if  in_ch ();
  cbz_out_if out_ch ();
  cbz_cfg_if cfg_ch ();

  cubic_bezier_point_generator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch),
    .cfg_port (cfg_ch)
  );

  cbz_point_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .end_count  (end_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("cubic_bezier_point_generator test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side backpressure
  initial begin
    int  stall_left;
    int  mode_left;
    bit  stalls_on;
    stall_left   = 0;
    mode_left    = 0;
    stalls_on    = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (!calm_tail && stalls_on && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(1, 8) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_curve(input logic [15:0] x0, input logic [15:0] y0,
                            input logic [15:0] x1, input logic [15:0] y1,
                            input logic [15:0] x2, input logic [15:0] y2,
                            input logic [15:0] x3, input logic [15:0] y3,
                            input logic [15:0] k);
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.ctrl_x0      = x0;
    in_ch.ctrl_y0      = y0;
    in_ch.ctrl_x1      = x1;
    in_ch.ctrl_y1      = y1;
    in_ch.ctrl_x2      = x2;
    in_ch.ctrl_y2      = y2;
    in_ch.ctrl_x3      = x3;
    in_ch.ctrl_y3      = y3;
    in_ch.sample_index = k;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_in(input int n);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [COLOR_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    reg_writes++;
    if (idx == CFG_T_STEP)
      cur_step = value[T_FRAC_BITS_DEF:0];
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_index();
    int reach;
    reach = (cur_step == 0) ? 65535 : (65536 + cur_step - 1) / cur_step;
    if (reach > 65535)
      reach = 65535;
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'(reach - $urandom_range(0, (reach > 2) ? 2 : reach));
      2:       return ($urandom_range(0, 1) != 0) ? 16'd0 : 16'hFFFF;
      default: return 16'($urandom_range(0, (reach < 65533) ? reach + 2 : 65535));
    endcase
  endfunction

  task automatic send_random_curve();
    if (in_gaps && !calm_tail && $urandom_range(0, 3) == 0)
      idle_in($urandom_range(1, 8));
    send_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_index());
  endtask

  initial begin
    int step_pick;
    rst_n              = 1'b0;
    calm_tail          = 1'b0;
    in_gaps            = 1'b1;
    reg_writes         = 0;
    idle_cycles        = 0;
    cur_step           = T_STEP_RESET;
    in_ch.valid        = 1'b0;
    in_ch.ctrl_x0      = '0;
    in_ch.ctrl_y0      = '0;
    in_ch.ctrl_x1      = '0;
    in_ch.ctrl_y1      = '0;
    in_ch.ctrl_x2      = '0;
    in_ch.ctrl_y2      = '0;
    in_ch.ctrl_x3      = '0;
    in_ch.ctrl_y3      = '0;
    in_ch.sample_index = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_T_STEP;
    cfg_ch.data        = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: start, interior, just short of and past the end
    send_curve(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_curve(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF);
    send_curve(0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0, 500);
    send_curve(16'h1234, 16'hFEDC, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 0, 992);
    send_curve(16'h1234, 16'hFEDC, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 0, 993);
    send_curve(7, 9, 16'hFFFF, 0, 0, 16'hFFFF, 16'h8001, 16'h7FFE, 0);

    // half step: rounding of an exact half, exact end
    wait_drained();
    write_reg(CFG_T_STEP, 24'h008000);
    write_reg(CFG_PIXEL_COLOR, 24'h000000);
    send_curve(0, 0, 0, 0, 0, 0, 4, 12, 1);
    send_curve(0, 0, 0, 0, 0, 0, 4, 12, 2);
    send_curve(16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 1);

    // full step: one sample reaches the end
    wait_drained();
    write_reg(CFG_T_STEP, 24'h010000);
    write_reg(CFG_PIXEL_COLOR, 24'hFFFFFF);
    send_curve(100, 200, 300, 400, 500, 600, 700, 800, 0);
    send_curve(100, 200, 300, 400, 500, 600, 700, 800, 1);

    // zero step never leaves the first point
    wait_drained();
    write_reg(CFG_T_STEP, 24'h000000);
    send_curve(16'hABCD, 16'h0F0F, 0, 16'hFFFF, 16'hFFFF, 0, 1, 2, 16'hFFFF);
    send_curve(16'hABCD, 16'h0F0F, 0, 16'hFFFF, 16'hFFFF, 0, 1, 2, 0);

    // smallest step with junk above the field, never reaches the end
    wait_drained();
    write_reg(CFG_T_STEP, 24'hFE0001);
    write_reg(CFG_PIXEL_COLOR, 24'hA5C3E1);
    send_curve(0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF);
    send_curve(0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0, 16'h8000);

    // widest step field value
    wait_drained();
    write_reg(CFG_T_STEP, 24'h01FFFF);
    send_curve(1, 2, 3, 4, 5, 6, 7, 8, 0);
    send_curve(1, 2, 3, 4, 5, 6, 7, 8, 1);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       step_pick = $urandom_range(1, 65536);
        1:       step_pick = $urandom_range(1, 300);
        2:       step_pick = $urandom_range(30000, 65536);
        3:       step_pick = $urandom_range(1, 5000);
        default: step_pick = $urandom_range(1, 65536);
      endcase
      wait_drained();
      calm_tail = (phase == 4);
      write_reg(CFG_T_STEP, {7'($urandom), 17'(step_pick)});
      write_reg(CFG_PIXEL_COLOR, 24'($urandom));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0)
          in_gaps = ($urandom_range(0, 2) != 0);
        send_random_curve();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("checked %0d curve points, %0d of them at the curve end, across %0d register writes",
             checked, end_count, reg_writes);
    if (fail_count == 0 && pending == 0)
      $display("cubic_bezier_point_generator test passed");
    else
      $display("cubic_bezier_point_generator test failed");
    $finish;
  end

endmodule

>>> files.f
sv/cbz_pkg.sv
sv/cbz_in_if.sv
sv/cbz_out_if.sv
sv/cbz_cfg_if.sv
sv/cbz_lerp_level.sv
sv/cubic_bezier_point_generator.sv
test/cbz_point_checker.sv
test/cubic_bezier_point_generator_tb.sv
